[hw/rtl/sls_pkg.sv]
package sls_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned VB_W      = 3;
  localparam int unsigned WIDX_W    = 4;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_0_7     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_8_15    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_16_23   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_24_31   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE       = 3'd5;

  localparam int unsigned ROUNDS    = 20;
  localparam int unsigned SUB_STEPS = 4;
  localparam int unsigned STEPS     = ROUNDS * SUB_STEPS;
  localparam int unsigned STEP_W    = $clog2(STEPS);

  typedef logic [31:0]        word_t;
  typedef logic [15:0][31:0]  state_t;

  typedef struct packed {
    logic             key_mode;
    logic [3:0][63:0] key;
    logic [63:0]      nonce;
  } cfg_t;

  typedef struct packed {
    word_t             msg;
    logic [VB_W-1:0]   vb;
    logic              last;
    logic [WIDX_W-1:0] widx;
    logic              blk_end;
    logic [3:0]        be;
  } ent_t;

  typedef struct packed {
    logic              pop;
    logic [WIDX_W-1:0] widx;
  } ks_req_t;

  typedef struct packed {
    logic  valid;
    word_t word;
  } ks_rsp_t;

  typedef struct packed {
    logic idle;
    logic done;
  } core_sts_t;

  // "expand 32-byte k" / "expand 16-byte k", word 0 in [0]
  localparam logic [3:0][31:0] SIGMA = {32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865};
  localparam logic [3:0][31:0] TAU   = {32'h6b206574, 32'h79622d36, 32'h3120646e, 32'h61707865};

  // quarter-round word indices a, b, c, d
  localparam logic [3:0] QR_COL [4][4] = '{
    '{4'd0,  4'd4,  4'd8,  4'd12},
    '{4'd5,  4'd9,  4'd13, 4'd1},
    '{4'd10, 4'd14, 4'd2,  4'd6},
    '{4'd15, 4'd3,  4'd7,  4'd11}
  };
  localparam logic [3:0] QR_ROW [4][4] = '{
    '{4'd0,  4'd1,  4'd2,  4'd3},
    '{4'd5,  4'd6,  4'd7,  4'd4},
    '{4'd10, 4'd11, 4'd8,  4'd9},
    '{4'd15, 4'd12, 4'd13, 4'd14}
  };

  function automatic word_t rotl(word_t v, int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // one add-rotate-xor step of all four quarter-rounds
  function automatic state_t salsa_step(state_t x, logic row, logic [1:0] sub);
    state_t     y;
    logic [3:0] ia, ib, ic, id;
    y = x;
    for (int q = 0; q < 4; q++) begin
      ia = row ? QR_ROW[q][0] : QR_COL[q][0];
      ib = row ? QR_ROW[q][1] : QR_COL[q][1];
      ic = row ? QR_ROW[q][2] : QR_COL[q][2];
      id = row ? QR_ROW[q][3] : QR_COL[q][3];
      case (sub)
        2'd0:    y[ib] = x[ib] ^ rotl(x[ia] + x[id], 7);
        2'd1:    y[ic] = x[ic] ^ rotl(x[ib] + x[ia], 9);
        2'd2:    y[id] = x[id] ^ rotl(x[ic] + x[ib], 13);
        default: y[ia] = x[ia] ^ rotl(x[id] + x[ic], 18);
      endcase
    end
    return y;
  endfunction

  function automatic state_t build_input(cfg_t cfg, logic [63:0] ctr);
    state_t           s;
    logic [3:0][31:0] c;
    logic [63:0]      h0, h1;
    c  = cfg.key_mode ? SIGMA : TAU;
    h0 = cfg.key_mode ? cfg.key[2] : cfg.key[0];
    h1 = cfg.key_mode ? cfg.key[3] : cfg.key[1];
    s[0]  = c[0];
    s[1]  = cfg.key[0][31:0];
    s[2]  = cfg.key[0][63:32];
    s[3]  = cfg.key[1][31:0];
    s[4]  = cfg.key[1][63:32];
    s[5]  = c[1];
    s[6]  = cfg.nonce[31:0];
    s[7]  = cfg.nonce[63:32];
    s[8]  = ctr[31:0];
    s[9]  = ctr[63:32];
    s[10] = c[2];
    s[11] = h0[31:0];
    s[12] = h0[63:32];
    s[13] = h1[31:0];
    s[14] = h1[63:32];
    s[15] = c[3];
    return s;
  endfunction

  function automatic logic [3:0] byte_en(logic [VB_W-1:0] vb);
    logic [3:0] be;
    case (vb)
      3'd0:    be = 4'b0000;
      3'd1:    be = 4'b0001;
      3'd2:    be = 4'b0011;
      3'd3:    be = 4'b0111;
      default: be = 4'b1111;
    endcase
    return be;
  endfunction

  function automatic word_t expand_mask(logic [3:0] be);
    word_t m;
    for (int i = 0; i < 4; i++) begin
      m[8*i +: 8] = {8{be[i]}};
    end
    return m;
  endfunction

endpackage

[hw/rtl/sls_if.sv]
interface sls_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] message_word;
  logic [2:0]  valid_bytes;
  logic        end_of_message;

  modport source (output valid, message_word, valid_bytes, end_of_message, input ready);
  modport sink   (input valid, message_word, valid_bytes, end_of_message, output ready);
endinterface

interface sls_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] cipher_word;
  logic [2:0]  out_valid_bytes;
  logic        out_last;

  modport source (output valid, cipher_word, out_valid_bytes, out_last, input ready);
  modport sink   (input valid, cipher_word, out_valid_bytes, out_last, output ready);
endinterface

interface sls_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/salsa20_stream_cipher.sv]
// Channel  Dir  Payload                                        Beat
// in_i     in   message_word, valid_bytes, end_of_message      valid & ready
// cfg_i    in   index (0 mode, 1-4 key, 5 nonce), data         valid & ready
// out_o    out  cipher_word, out_valid_bytes, out_last         valid & ready
//
// One word per cycle within a message while keystream is ready and the output is not
// stalled; each input beat is registered in the queue, then in the output register.
// NUM_CORES iterative cores each turn a 64-byte block (load, 80 steps, final add,
// hand-off); blocks are made ahead in counter order, one in flight per core.
// Reset or a write to index 0-5 clears block counter, word position, prefetched blocks.
// Input and output stall independently through the 4-entry queue and output register.
module salsa20_stream_cipher #(
  parameter int unsigned NUM_CORES = 6
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sls_in_if.sink    in_i,
  sls_cfg_if.sink   cfg_i,
  sls_out_if.source out_o
);

  sls_pkg::cfg_t    cfg_q;
  logic             cfg_hit;
  logic             flush;
  sls_pkg::ent_t    ent;
  logic             ent_valid;
  logic             ent_pop;
  sls_pkg::ks_req_t ks_req;
  sls_pkg::ks_rsp_t ks_rsp;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    unique case (cfg_i.index)
      sls_pkg::REG_KEY_MODE,
      sls_pkg::REG_KEY_0_7,
      sls_pkg::REG_KEY_8_15,
      sls_pkg::REG_KEY_16_23,
      sls_pkg::REG_KEY_24_31,
      sls_pkg::REG_NONCE: cfg_hit = 1'b1;
      default:            cfg_hit = 1'b0;
    endcase
  end

  assign flush = cfg_i.valid && cfg_i.ready && cfg_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.key_mode <= 1'b1;
      cfg_q.key      <= '0;
      cfg_q.nonce    <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        sls_pkg::REG_KEY_MODE:  cfg_q.key_mode <= cfg_i.data[0];
        sls_pkg::REG_KEY_0_7:   cfg_q.key[0]   <= cfg_i.data;
        sls_pkg::REG_KEY_8_15:  cfg_q.key[1]   <= cfg_i.data;
        sls_pkg::REG_KEY_16_23: cfg_q.key[2]   <= cfg_i.data;
        sls_pkg::REG_KEY_24_31: cfg_q.key[3]   <= cfg_i.data;
        sls_pkg::REG_NONCE:     cfg_q.nonce    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  sls_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .flush_i     (flush),
    .in_i        (in_i),
    .ent_o       (ent),
    .ent_valid_o (ent_valid),
    .ent_pop_i   (ent_pop)
  );

  sls_keygen #(
    .NUM_CORES (NUM_CORES)
  ) u_keygen (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .flush_i  (flush),
    .cfg_i    (cfg_q),
    .ks_req_i (ks_req),
    .ks_rsp_o (ks_rsp)
  );

  sls_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ent_i       (ent),
    .ent_valid_i (ent_valid),
    .ent_pop_o   (ent_pop),
    .ks_req_o    (ks_req),
    .ks_rsp_i    (ks_rsp),
    .out_o       (out_o)
  );

endmodule

[hw/rtl/sls_front.sv]
module sls_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          flush_i,
  sls_in_if.sink        in_i,
  output sls_pkg::ent_t ent_o,
  output logic          ent_valid_o,
  input  logic          ent_pop_i
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  sls_pkg::ent_t                 mem_q [DEPTH];
  logic [PW-1:0]                 wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]                 cnt_q, cnt_d;
  logic [sls_pkg::WIDX_W-1:0]    pos_q, pos_d;
  logic                          push;
  sls_pkg::ent_t                 ent_new;

  assign in_i.ready  = (cnt_q != CW'(DEPTH));
  assign push        = in_i.valid && in_i.ready;
  assign ent_valid_o = (cnt_q != '0);
  assign ent_o       = mem_q[rd_q];

  always_comb begin
    ent_new.msg     = in_i.message_word;
    ent_new.vb      = in_i.valid_bytes;
    ent_new.last    = in_i.end_of_message;
    ent_new.widx    = pos_q;
    ent_new.blk_end = in_i.end_of_message || (pos_q == '1);
    ent_new.be      = sls_pkg::byte_en(in_i.valid_bytes);
  end

  always_comb begin
    pos_d = pos_q;
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      pos_d = in_i.end_of_message ? '0 : pos_q + 1'b1;
      wr_d  = wr_q + 1'b1;
    end
    if (ent_pop_i) begin
      rd_d = rd_q + 1'b1;
    end
    case ({push, ent_pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
    if (flush_i) begin
      pos_d = '0;
      wr_d  = '0;
      rd_d  = '0;
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      pos_q <= pos_d;
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= ent_new;
    end
  end

endmodule

[hw/rtl/sls_core.sv]
module sls_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               flush_i,
  input  sls_pkg::cfg_t      cfg_i,
  input  logic               start_i,
  input  logic [63:0]        ctr_i,
  input  logic               take_i,
  output sls_pkg::core_sts_t sts_o,
  output sls_pkg::state_t    ks_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]                 st_q, st_d;
  logic [sls_pkg::STEP_W-1:0] step_q, step_d;
  sls_pkg::state_t            x_q, x_d;
  sls_pkg::state_t            in_fin;
  logic [63:0]                ctr_q, ctr_d;

  assign in_fin     = sls_pkg::build_input(cfg_i, ctr_q);
  assign sts_o.idle = (st_q == ST_IDLE);
  assign sts_o.done = (st_q == ST_DONE);
  assign ks_o       = x_q;

  always_comb begin
    st_d   = st_q;
    step_d = step_q;
    x_d    = x_q;
    ctr_d  = ctr_q;
    unique case (st_q)
      ST_IDLE: begin
        if (start_i) begin
          x_d    = sls_pkg::build_input(cfg_i, ctr_i);
          ctr_d  = ctr_i;
          step_d = '0;
          st_d   = ST_RUN;
        end
      end
      ST_RUN: begin
        x_d    = sls_pkg::salsa_step(x_q, step_q[2], step_q[1:0]);
        step_d = step_q + 1'b1;
        if (step_q == sls_pkg::STEP_W'(sls_pkg::STEPS - 1)) begin
          st_d = ST_FIN;
        end
      end
      ST_FIN: begin
        for (int i = 0; i < 16; i++) begin
          x_d[i] = x_q[i] + in_fin[i];
        end
        st_d = ST_DONE;
      end
      ST_DONE: begin
        if (take_i) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
    if (flush_i) begin
      st_d = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      step_q <= '0;
    end else begin
      st_q   <= st_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    ctr_q <= ctr_d;
  end

endmodule

[hw/rtl/sls_keygen.sv]
module sls_keygen #(
  parameter int unsigned NUM_CORES = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             flush_i,
  input  sls_pkg::cfg_t    cfg_i,
  input  sls_pkg::ks_req_t ks_req_i,
  output sls_pkg::ks_rsp_t ks_rsp_o
);

  localparam int unsigned PW = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;

  logic [PW-1:0]       wr_q, wr_d, rd_q, rd_d;
  logic [63:0]         ctr_q, ctr_d;
  sls_pkg::core_sts_t  sts [NUM_CORES];
  sls_pkg::state_t     ks  [NUM_CORES];
  logic                issue;

  function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
    return (p == PW'(NUM_CORES - 1)) ? '0 : p + 1'b1;
  endfunction

  for (genvar i = 0; i < NUM_CORES; i++) begin : g_core
    sls_core u_core (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .flush_i (flush_i),
      .cfg_i   (cfg_i),
      .start_i (issue && (wr_q == PW'(i))),
      .ctr_i   (ctr_q),
      .take_i  (ks_req_i.pop && (rd_q == PW'(i))),
      .sts_o   (sts[i]),
      .ks_o    (ks[i])
    );
  end

  assign issue          = sts[wr_q].idle && !flush_i;
  assign ks_rsp_o.valid = sts[rd_q].done;
  assign ks_rsp_o.word  = ks[rd_q][ks_req_i.widx];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    ctr_d = ctr_q;
    if (issue) begin
      wr_d  = ptr_inc(wr_q);
      ctr_d = ctr_q + 64'd1;
    end
    if (ks_req_i.pop) begin
      rd_d = ptr_inc(rd_q);
    end
    if (flush_i) begin
      wr_d  = '0;
      rd_d  = '0;
      ctr_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      ctr_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      ctr_q <= ctr_d;
    end
  end

endmodule

[hw/rtl/sls_back.sv]
module sls_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sls_pkg::ent_t    ent_i,
  input  logic             ent_valid_i,
  output logic             ent_pop_o,
  output sls_pkg::ks_req_t ks_req_o,
  input  sls_pkg::ks_rsp_t ks_rsp_i,
  sls_out_if.source        out_o
);

  logic                      vld_q, vld_d;
  sls_pkg::word_t            cw_q;
  logic [sls_pkg::VB_W-1:0]  vb_q;
  logic                      last_q;
  logic                      fire;

  assign fire          = ent_valid_i && ks_rsp_i.valid && (!vld_q || out_o.ready);
  assign ent_pop_o     = fire;
  assign ks_req_o.pop  = fire && ent_i.blk_end;
  assign ks_req_o.widx = ent_i.widx;

  assign out_o.valid           = vld_q;
  assign out_o.cipher_word     = cw_q;
  assign out_o.out_valid_bytes = vb_q;
  assign out_o.out_last        = last_q;

  always_comb begin
    vld_d = vld_q;
    if (fire) begin
      vld_d = 1'b1;
    end else if (out_o.ready) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      cw_q   <= (ent_i.msg ^ ks_rsp_i.word) & sls_pkg::expand_mask(ent_i.be);
      vb_q   <= ent_i.vb;
      last_q <= ent_i.last;
    end
  end

endmodule

[hw/rtl/sls_checker.sv]
module sls_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] cipher_word_i,
  input logic [2:0]  out_valid_bytes_i
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(cipher_word_i))
    else $error("output beat changed while stalled");

  // bytes past the valid count are zero
  a_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      (out_valid_bytes_i != 3'd0 || cipher_word_i == 32'd0) &&
      (out_valid_bytes_i != 3'd1 || cipher_word_i[31:8] == 24'd0) &&
      (out_valid_bytes_i != 3'd2 || cipher_word_i[31:16] == 16'd0) &&
      (out_valid_bytes_i != 3'd3 || cipher_word_i[31:24] == 8'd0))
    else $error("unmasked byte beyond valid count");

  // queue cannot fill without an input beat
  a_ready_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i && !in_valid_i |=> in_ready_i)
    else $error("input ready dropped without a beat");

endmodule

bind salsa20_stream_cipher sls_checker u_sls_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .cipher_word_i     (out_o.cipher_word),
  .out_valid_bytes_i (out_o.out_valid_bytes)
);
